// ===== src/wkw_pkg.sv =====
// ----------------------------------------------------------------------------
// wkw_pkg
// Shared types and constants for the windowed keyed watchdog.
// ----------------------------------------------------------------------------
package wkw_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [4:0] OFS_CTRL    = 5'd0;
   localparam logic [4:0] OFS_IRQ     = 5'd4;
   localparam logic [4:0] OFS_TIMEOUT = 5'd8;
   localparam logic [4:0] OFS_WINDOW  = 5'd12;
   localparam logic [4:0] OFS_SERVICE = 5'd16;
   localparam logic [4:0] OFS_COUNT   = 5'd20;
   localparam logic [4:0] OFS_KEY     = 5'd24;

   localparam int CTL_ENABLE_BIT   = 0;
   localparam int CTL_SOFTLOCK_BIT = 4;
   localparam int CTL_HARDLOCK_BIT = 5;
   localparam int CTL_ITR_BIT      = 6;
   localparam int CTL_WINDOWED_BIT = 7;
   localparam int CTL_RIA_BIT      = 8;
   localparam int CTL_KEYED_BIT    = 9;

   localparam logic [31:0] CTL_RESET  = 32'hff00_011b;
   localparam logic [31:0] TO_RESET   = 32'h0003_fde0;
   localparam logic [31:0] TO_MIN     = 32'h0000_0100;
   localparam logic [15:0] FIX_FIRST  = 16'hc520;
   localparam logic [31:0] FIX_SECOND = 32'h0000_d928;

   typedef struct packed {
      logic [1:0]  operation;
      logic [4:0]  reg_offset;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_level;
      logic        system_reset;
      logic        invalid_access;
   } rsp_type;

   // (17 * key + 3) mod 2^16
   function automatic logic [15:0] next_key(input logic [15:0] key);
      logic [15:0] shifted;
      begin
         shifted  = {key[11:0], 4'd0};
         next_key = shifted + key + 16'd3;
      end
   endfunction

endpackage

// ===== src/wkw_core.sv =====
// ----------------------------------------------------------------------------
// wkw_core
// Watchdog register file, down counter and service logic; one item per
// cycle, result formed combinationally from the current state.
// ----------------------------------------------------------------------------
module wkw_core
   import wkw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    item_valid,
   input  req_type item,
   output rsp_type result
);

   logic [31:0] control_ff, control_in;
   logic        irq_ff, irq_in;
   logic [31:0] timeout_ff, timeout_in;
   logic [31:0] window_ff, window_in;
   logic [15:0] last_svc_ff, last_svc_in;
   logic [15:0] key_ff, key_in;
   logic [31:0] count_ff, count_in;
   logic [1:0]  seen_ff, seen_in;

   logic        unlocked;
   logic        enabled;
   logic [1:0]  seen_inc;
   logic [15:0] svc_low;
   logic [31:0] rd;
   logic        rst;
   logic        inv;

   always_comb begin
      control_in  = control_ff;
      irq_in      = irq_ff;
      timeout_in  = timeout_ff;
      window_in   = window_ff;
      last_svc_in = last_svc_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      seen_in     = seen_ff;
      rd          = '0;
      rst         = 1'b0;
      inv         = 1'b0;
      unlocked    = !control_ff[CTL_SOFTLOCK_BIT] && !control_ff[CTL_HARDLOCK_BIT];
      enabled     = control_ff[CTL_ENABLE_BIT];
      seen_inc    = seen_ff + 2'd1;
      svc_low     = item.write_data[15:0];

      case (item.operation)
         OP_TICK: begin
            if (enabled) begin
               if (count_ff <= 32'd1) begin
                  count_in = timeout_ff;
                  if (control_ff[CTL_ITR_BIT] && seen_inc == 2'd1) begin
                     seen_in = seen_inc;
                     irq_in  = 1'b1;
                  end else begin
                     rst     = 1'b1;
                     seen_in = 2'd0;
                  end
               end else begin
                  count_in = count_ff - 32'd1;
               end
            end
         end
         OP_READ: begin
            unique case (item.reg_offset)
               OFS_CTRL:    rd = control_ff;
               OFS_IRQ:     rd = {31'd0, irq_ff};
               OFS_TIMEOUT: rd = timeout_ff;
               OFS_WINDOW:  rd = window_ff;
               OFS_COUNT:   rd = enabled ? 32'd0 : count_ff;
               default:     rd = '0;
            endcase
         end
         OP_WRITE: begin
            unique case (item.reg_offset)
               OFS_CTRL: begin
                  if (unlocked) control_in = item.write_data;
               end
               OFS_IRQ: begin
                  if (item.write_data[0]) irq_in = 1'b0;
               end
               OFS_TIMEOUT: begin
                  if (unlocked) begin
                     timeout_in = item.write_data;
                     if (enabled || last_svc_ff != 16'd0)
                        count_in = (item.write_data > TO_MIN) ? item.write_data : TO_MIN;
                  end
               end
               OFS_WINDOW: begin
                  if (unlocked) window_in = item.write_data;
               end
               OFS_SERVICE: begin
                  if (control_ff[CTL_WINDOWED_BIT] && !(count_ff < window_ff)) begin
                     inv = 1'b1;
                     rst = control_ff[CTL_RIA_BIT] && enabled;
                  end else begin
                     last_svc_in = svc_low;
                     if (control_ff[CTL_KEYED_BIT]) begin
                        if (svc_low == next_key(key_ff)) begin
                           key_in   = svc_low;
                           count_in = timeout_ff;
                           seen_in  = 2'd0;
                        end
                     end else if (last_svc_ff == FIX_FIRST && item.write_data == FIX_SECOND) begin
                        control_in[CTL_SOFTLOCK_BIT] = 1'b0;
                        count_in = timeout_ff;
                        seen_in  = 2'd0;
                     end
                  end
               end
               OFS_KEY: begin
                  if (unlocked) key_in = svc_low;
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      result.read_data      = rd;
      result.irq_level      = irq_in;
      result.system_reset   = rst;
      result.invalid_access = inv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff  <= CTL_RESET;
         irq_ff      <= 1'b0;
         timeout_ff  <= TO_RESET;
         window_ff   <= '0;
         last_svc_ff <= '0;
         key_ff      <= '0;
         count_ff    <= TO_RESET;
         seen_ff     <= '0;
      end else if (item_valid) begin
         control_ff  <= control_in;
         irq_ff      <= irq_in;
         timeout_ff  <= timeout_in;
         window_ff   <= window_in;
         last_svc_ff <= last_svc_in;
         key_ff      <= key_in;
         count_ff    <= count_in;
         seen_ff     <= seen_in;
      end
   end

endmodule

// ===== src/windowed_keyed_watchdog.sv =====
// ----------------------------------------------------------------------------
// windowed_keyed_watchdog
// Watchdog with fixed-pair or keyed service, window check and interrupt-first
// timeout; each tick, read or write transfer yields one result transfer.
// ----------------------------------------------------------------------------
// Path: an input transfer is captured in the input register, then the state
//   update goes into the result register, which raises result valid; a
//   stalled result register holds the input register back.
// Throughput: one item per cycle while rsp_tready is high; the result register
//   and the input register each hand over while the next side drains.
// Reset: synchronous, active high; restores all watchdog registers to their
//   power-on values and empties both pipeline stages.
module windowed_keyed_watchdog
   import wkw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [4:0] reg_offset, [36:5] write_data, [39:37] zero
   input  logic [1:0]  req_tuser,  // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // [31:0] read_data, [32] irq_level,
                                   // [33] system_reset, [34] invalid_access, [39:35] zero
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type core_rsp;
   logic    advance;
   logic    take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   wkw_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (in_item_ff),
      .result     (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff.operation  <= req_tuser;
         in_item_ff.reg_offset <= req_tdata[4:0];
         in_item_ff.write_data <= req_tdata[36:5];
      end
      if (advance) out_rsp_ff <= core_rsp;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_rsp_ff.invalid_access, out_rsp_ff.system_reset,
                        out_rsp_ff.irq_level, out_rsp_ff.read_data};

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for windowed_keyed_watchdog. A shadow copy of the
// watchdog registers predicts the result of every accepted tick, read or
// write transfer. Each result transfer is compared field by field in order.
// A directed opening walks the lock, fixed-pair service, timeout, window and
// keyed paths. Random traffic follows, mostly well-formed service sequences,
// with random gaps on both sides and one long back-pressure stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import wkw_pkg::*;

   localparam logic [1:0] OP_NOP     = 2'd3;
   localparam int         RAND_ITEMS = 400;
   localparam int         HOLD_LEN   = 60;
   localparam int         IDLE_LIMIT = 1000;

   class watchdog_shadow;
      logic [31:0] ctrl;
      logic        irq;
      logic [31:0] timeout_val;
      logic [31:0] window_val;
      logic [15:0] last_word;
      logic [15:0] key;
      logic [31:0] down_cnt;
      logic [1:0]  timeouts;
      rsp_type     pending_results[$];
      int          errors;

      function new();
         ctrl        = CTL_RESET;
         irq         = 1'b0;
         timeout_val = TO_RESET;
         window_val  = '0;
         last_word   = '0;
         key         = '0;
         down_cnt    = TO_RESET;
         timeouts    = '0;
         errors      = 0;
      endfunction

      function logic [15:0] key_after(logic [15:0] k);
         logic [31:0] prod;
         prod = k * 17 + 3;
         return prod[15:0];
      endfunction

      function void reload();
         down_cnt = timeout_val;
         timeouts = '0;
      endfunction

      // apply one accepted item to the shadow registers and queue its result
      function void note_item(logic [1:0] op, logic [4:0] ofs, logic [31:0] data);
         rsp_type     r;
         logic        unlocked;
         logic [15:0] low;
         r        = '0;
         unlocked = !ctrl[CTL_SOFTLOCK_BIT] && !ctrl[CTL_HARDLOCK_BIT];
         low      = data[15:0];
         case (op)
            OP_TICK: begin
               if (ctrl[CTL_ENABLE_BIT]) begin
                  if (down_cnt <= 32'd1) begin
                     down_cnt = timeout_val;
                     if (ctrl[CTL_ITR_BIT]) begin
                        timeouts = timeouts + 2'd1;
                        if (timeouts == 2'd1) begin
                           irq = 1'b1;
                        end else begin
                           r.system_reset = 1'b1;
                           timeouts = '0;
                        end
                     end else begin
                        r.system_reset = 1'b1;
                        timeouts = '0;
                     end
                  end else begin
                     down_cnt = down_cnt - 32'd1;
                  end
               end
            end
            OP_READ: begin
               case (ofs)
                  OFS_CTRL:    r.read_data = ctrl;
                  OFS_IRQ:     r.read_data = {31'd0, irq};
                  OFS_TIMEOUT: r.read_data = timeout_val;
                  OFS_WINDOW:  r.read_data = window_val;
                  OFS_COUNT:   r.read_data = ctrl[CTL_ENABLE_BIT] ? 32'd0 : down_cnt;
                  default:     r.read_data = '0;
               endcase
            end
            OP_WRITE: begin
               case (ofs)
                  OFS_CTRL: if (unlocked) ctrl = data;
                  OFS_IRQ:  if (data[0]) irq = 1'b0;
                  OFS_TIMEOUT: begin
                     if (unlocked) begin
                        timeout_val = data;
                        if (ctrl[CTL_ENABLE_BIT] || last_word != 16'd0)
                           down_cnt = (data > TO_MIN) ? data : TO_MIN;
                     end
                  end
                  OFS_WINDOW: if (unlocked) window_val = data;
                  OFS_SERVICE: begin
                     if (ctrl[CTL_WINDOWED_BIT] && !(down_cnt < window_val)) begin
                        r.invalid_access = 1'b1;
                        if (ctrl[CTL_RIA_BIT] && ctrl[CTL_ENABLE_BIT])
                           r.system_reset = 1'b1;
                     end else begin
                        if (ctrl[CTL_KEYED_BIT]) begin
                           if (low == key_after(key)) begin
                              key = low;
                              reload();
                           end
                        end else if (last_word == FIX_FIRST && data == FIX_SECOND) begin
                           ctrl[CTL_SOFTLOCK_BIT] = 1'b0;
                           reload();
                        end
                        last_word = low;
                     end
                  end
                  OFS_KEY: if (unlocked) key = low;
                  default: ;
               endcase
            end
            default: ;
         endcase
         r.irq_level = irq;
         pending_results.push_back(r);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [39:0] word);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result transfer with nothing pending, expected none, actual %h",
                     $time, word);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         check_field("read_data", want.read_data, word[31:0]);
         check_field("irq_level", {31'd0, want.irq_level}, {31'd0, word[32]});
         check_field("system_reset", {31'd0, want.system_reset}, {31'd0, word[33]});
         check_field("invalid_access", {31'd0, want.invalid_access}, {31'd0, word[34]});
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // [4:0] reg_offset, [36:5] write_data, [39:37] zero
   logic [1:0]  req_tuser = '0;  // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;       // [31:0] read_data, [32] irq_level,
                                 // [33] system_reset, [34] invalid_access

   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   bit hold_request = 1'b0;
   int idle_cycles  = 0;

   watchdog_shadow shadow = new();

   windowed_keyed_watchdog dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic send_item(input logic [1:0] op, input logic [4:0] ofs,
                            input logic [31:0] data);
      int gap;
      gap = send_idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, data, ofs};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      shadow.note_item(op, ofs, data);
   endtask

   // random item shaped by the current register state so that services
   // mostly succeed and the counter runs out often
   function automatic void choose_item(output logic [1:0] op, output logic [4:0] ofs,
                                       output logic [31:0] data);
      int          pick;
      int          sel;
      logic [31:0] val;
      logic        soft_locked;
      pick        = $urandom_range(0, 99);
      sel         = $urandom_range(0, 19);
      val         = $urandom;
      ofs         = 5'($urandom_range(0, 31));
      data        = $urandom;
      soft_locked = shadow.ctrl[CTL_SOFTLOCK_BIT];
      if (pick < 4) begin
         op = OP_NOP;
      end else if (pick < 38) begin
         op = OP_TICK;
      end else if (pick < 52) begin
         op = OP_READ;
         if ($urandom_range(0, 5) != 0) ofs = 5'($urandom_range(0, 6) * 4);
      end else begin
         op = OP_WRITE;
         if (soft_locked && sel < 8) sel = 10;
         case (sel)
            0, 1, 2: begin
               ofs = OFS_CTRL;
               val[CTL_HARDLOCK_BIT] = 1'b0;
               val[CTL_ENABLE_BIT]   = ($urandom_range(0, 9) < 8);
               val[CTL_SOFTLOCK_BIT] = ($urandom_range(0, 5) == 0);
               // soft lock only where the fixed pair can always undo it
               if (val[CTL_SOFTLOCK_BIT]) begin
                  val[CTL_KEYED_BIT]    = 1'b0;
                  val[CTL_WINDOWED_BIT] = 1'b0;
               end
               data = val;
            end
            3: ofs = OFS_IRQ;
            4, 5: begin
               ofs = OFS_TIMEOUT;
               if ($urandom_range(0, 3) != 0) data = $urandom_range(0, 6);
            end
            6, 7: begin
               ofs = OFS_WINDOW;
               if ($urandom_range(0, 3) != 0) data = $urandom_range(0, 12);
            end
            8, 9, 10, 11, 12, 13: begin
               ofs = OFS_SERVICE;
               if (shadow.ctrl[CTL_KEYED_BIT]) begin
                  if ($urandom_range(0, 3) != 0)
                     data = {val[31:16], shadow.key_after(shadow.key)};
               end else if (shadow.last_word == FIX_FIRST) begin
                  if ($urandom_range(0, 4) != 0) data = FIX_SECOND;
               end else if ($urandom_range(0, 4) != 0) begin
                  data = {val[31:16], FIX_FIRST};
               end
            end
            14: ofs = OFS_KEY;
            15: ofs = OFS_COUNT;
            default: ;
         endcase
      end
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            hold_request = 1'b0;
         end
         stall = recv_idle_on ? $urandom_range(0, 7) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) shadow.check_result(rsp_tdata);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [1:0]  op;
      logic [4:0]  ofs;
      logic [31:0] data;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset values, including write-only and unused offsets
      send_item(OP_READ, OFS_CTRL, 32'd0);
      send_item(OP_READ, OFS_IRQ, 32'd0);
      send_item(OP_READ, OFS_TIMEOUT, 32'd0);
      send_item(OP_READ, OFS_WINDOW, 32'd0);
      send_item(OP_READ, OFS_COUNT, 32'd0);
      send_item(OP_READ, OFS_KEY, 32'd0);
      send_item(OP_READ, 5'd31, 32'hffff_ffff);
      // locked write is dropped, then the fixed pair unlocks
      send_item(OP_WRITE, OFS_CTRL, 32'd0);
      send_item(OP_WRITE, OFS_SERVICE, {16'hffff, FIX_FIRST});
      send_item(OP_WRITE, OFS_SERVICE, FIX_SECOND);
      send_item(OP_WRITE, OFS_TIMEOUT, 32'hffff_ffff);
      send_item(OP_WRITE, OFS_TIMEOUT, 32'd2);
      send_item(OP_WRITE, OFS_CTRL, 32'h0000_0040);
      send_item(OP_READ, OFS_COUNT, 32'd0);
      send_item(OP_WRITE, OFS_CTRL, 32'h0000_0041);
      // service reloads a tiny count: interrupt first, then reset request
      send_item(OP_WRITE, OFS_SERVICE, {16'd0, FIX_FIRST});
      send_item(OP_WRITE, OFS_SERVICE, FIX_SECOND);
      repeat (4) send_item(OP_TICK, 5'd0, 32'd0);
      send_item(OP_WRITE, OFS_IRQ, 32'd1);
      send_item(OP_NOP, OFS_CTRL, 32'hffff_ffff);
      // closed window: service is a miss and requests reset
      send_item(OP_WRITE, OFS_CTRL, 32'h0000_0181);
      send_item(OP_WRITE, OFS_SERVICE, FIX_SECOND);
      // keyed service
      send_item(OP_WRITE, OFS_CTRL, 32'h0000_0201);
      send_item(OP_WRITE, OFS_KEY, 32'hffff_0005);
      send_item(OP_WRITE, OFS_SERVICE, 32'h0000_0058);

      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i % 50 == 0) begin
            send_idle_on = ($urandom_range(0, 2) != 0);
            recv_idle_on = ($urandom_range(0, 2) != 0);
         end
         if (i == RAND_ITEMS / 2) begin
            send_idle_on = 1'b0;
            hold_request = 1'b1;
         end
         choose_item(op, ofs, data);
         send_item(op, ofs, data);
      end

      // hard lock: only reset clears it, so it comes last
      if (shadow.ctrl[CTL_SOFTLOCK_BIT]) begin
         send_item(OP_WRITE, OFS_SERVICE, {16'd0, FIX_FIRST});
         send_item(OP_WRITE, OFS_SERVICE, FIX_SECOND);
      end
      send_item(OP_WRITE, OFS_CTRL, 32'h0000_0021);
      send_item(OP_WRITE, OFS_CTRL, 32'd0);
      send_item(OP_WRITE, OFS_TIMEOUT, 32'd5);
      send_item(OP_WRITE, OFS_WINDOW, 32'd5);
      send_item(OP_WRITE, OFS_KEY, 32'd7);
      send_item(OP_READ, OFS_CTRL, 32'd0);
      send_item(OP_READ, OFS_TIMEOUT, 32'd0);
      send_item(OP_READ, OFS_WINDOW, 32'd0);
      req_tvalid <= 1'b0;

      while (shadow.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (shadow.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
